FILE: design/cdr_pkg.sv
// Package for the calendar date register: payload types, command and status codes,
// field widths and the shared leap-year and month-length functions. No dependencies.
package cdr_pkg;

	localparam int unsigned DAY_W = 5;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned YEAR_W = 14;
	localparam int unsigned MAX_YEAR_DEF = 9999;

	typedef enum logic [1:0] {
		FUNC_SET_DATE,
		FUNC_SET_DAY,
		FUNC_SET_MONTH,
		FUNC_SET_YEAR
	} func_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_BAD_DAY,
		ST_BAD_MONTH,
		ST_BAD_YEAR
	} status_t;

	typedef struct packed {
		logic [DAY_W-1:0] day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0] year;
	} date_t;

	typedef struct packed {
		func_t func;
		logic [DAY_W-1:0] new_day;
		logic [MONTH_W-1:0] new_month;
		logic [YEAR_W-1:0] new_year;
	} cmd_t;

	typedef struct packed {
		logic [2:0] weekday;
		logic leap;
		logic month_end;
	} info_t;

	typedef struct packed {
		status_t status;
		logic [DAY_W-1:0] cur_day;
		logic [MONTH_W-1:0] cur_month;
		logic [YEAR_W-1:0] cur_year;
		logic [2:0] weekday;
		logic leap;
		logic month_end;
	} res_t;

	localparam date_t RESET_DATE = '{day: 5'd1, month: 4'd1, year: 14'd1970};

	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam int unsigned RECIP_SHIFT = 19;

	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [26:0] prod;
		logic [7:0] q100;
		logic [14:0] back;
		logic cent;
		prod = 27'(y) * 27'(RECIP_100);
		q100 = prod[26:RECIP_SHIFT];
		back = 15'(q100) * 15'd100;
		cent = (back == 15'(y));
		return (y[1:0] == 2'd0) && (!cent || (q100[1:0] == 2'd0));
	endfunction

	function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
			input logic [YEAR_W-1:0] y);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd2: len = is_leap(y) ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic logic [2:0] month_offset(input logic [MONTH_W-1:0] m);
		logic [2:0] off;
		unique case (m)
			4'd2: off = 3'd3;
			4'd3: off = 3'd2;
			4'd4: off = 3'd5;
			4'd5: off = 3'd0;
			4'd6: off = 3'd3;
			4'd7: off = 3'd5;
			4'd8: off = 3'd1;
			4'd9: off = 3'd4;
			4'd10: off = 3'd6;
			4'd11: off = 3'd2;
			4'd12: off = 3'd4;
			default: off = 3'd0;
		endcase
		return off;
	endfunction

endpackage

FILE: design/cdr_cmd_if.sv
// Command channel of the calendar date register: valid, ready and one command word.
// Depends on cdr_pkg for the command type.
interface cdr_cmd_if import cdr_pkg::*;;
	logic valid;
	logic ready;
	cmd_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: design/cdr_res_if.sv
// Result channel of the calendar date register: valid, ready and one result word.
// Depends on cdr_pkg for the result type.
interface cdr_res_if import cdr_pkg::*;;
	logic valid;
	logic ready;
	res_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: design/cdr_date_info.sv
// Derived facts of a committed date: weekday by the offset table, leap flag, last-day flag.
// Depends on cdr_pkg for the date types and calendar functions.
module cdr_date_info import cdr_pkg::*; (
	input date_t date,
	output info_t info
);

	logic [14:0] yy;
	logic [27:0] prod;
	logic [8:0] q100;
	logic [6:0] q400;
	logic [15:0] sum;
	logic [5:0] fold1;
	logic [3:0] fold2;
	logic [2:0] wd;

	always_comb begin
		// Shifting the year by 400 keeps the weekday and keeps every term positive.
		yy = 15'(date.year) + 15'd400 - ((date.month <= 4'd2) ? 15'd1 : 15'd0);
		prod = 28'(yy) * 28'(RECIP_100);
		q100 = prod[27:RECIP_SHIFT];
		q400 = q100[8:2];
		sum = 16'(yy) + 16'(yy[14:2]) - 16'(q100) + 16'(q400)
			+ 16'(month_offset(date.month)) + 16'(date.day);
		// Eight is one modulo seven, so the octal digits fold.
		fold1 = 6'(sum[2:0]) + 6'(sum[5:3]) + 6'(sum[8:6]) + 6'(sum[11:9])
			+ 6'(sum[14:12]) + 6'(sum[15]);
		fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
		wd = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
	end

	assign info.weekday = wd;
	assign info.leap = is_leap(date.year);
	assign info.month_end = (date.day == month_length(date.month, date.year));

endmodule

FILE: design/calendar_date_register.sv
// Calendar date register: a command passes the input register, the commit register and the result register,
// and one command word is taken every cycle while results are drained.
// Check and commit of the stored date happen together from the input register,
// since each command sees the date that the one before it left.
// Weekday, leap and last-day flags are formed in the next stage from the committed date.
// Reset clears the pipeline and sets the date to January 1, 1970.
module calendar_date_register import cdr_pkg::*; #(
	parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
	input logic clk,
	input logic arst_n,
	cdr_cmd_if.sink cmd,
	cdr_res_if.source res
);

	localparam logic [YEAR_W-1:0] YEAR_LIMIT = YEAR_W'(MAX_YEAR);

	date_t date_q;
	cmd_t cmd_s1;
	logic v_s1;
	date_t date_s2;
	status_t status_s2;
	logic v_s2;
	res_t res_s3;
	logic v_s3;

	logic ready1;
	logic ready2;
	logic ready3;
	logic fire1;
	date_t cand;
	logic month_ok;
	logic year_ok;
	logic day_ok;
	status_t status_s1;
	info_t info;

	assign ready3 = !v_s3 || res.ready;
	assign ready2 = !v_s2 || ready3;
	assign ready1 = !v_s1 || ready2;
	assign fire1 = v_s1 && ready2;
	assign cmd.ready = ready1;

	always_comb begin
		cand = date_q;
		unique case (cmd_s1.func)
			FUNC_SET_DATE: begin
				cand = '{day: cmd_s1.new_day, month: cmd_s1.new_month, year: cmd_s1.new_year};
			end
			FUNC_SET_DAY: cand.day = cmd_s1.new_day;
			FUNC_SET_MONTH: cand.month = cmd_s1.new_month;
			FUNC_SET_YEAR: cand.year = cmd_s1.new_year;
		endcase
		month_ok = (cand.month >= 4'd1) && (cand.month <= 4'd12);
		year_ok = (cand.year <= YEAR_LIMIT);
		day_ok = (cand.day != '0) && (cand.day <= month_length(cand.month, cand.year));
		status_s1 = ST_OK;
		if (!(month_ok && year_ok && day_ok)) begin
			unique case (cmd_s1.func)
				FUNC_SET_DATE: begin
					priority if (!year_ok) status_s1 = ST_BAD_YEAR;
					else if (!month_ok) status_s1 = ST_BAD_MONTH;
					else status_s1 = ST_BAD_DAY;
				end
				FUNC_SET_DAY: status_s1 = ST_BAD_DAY;
				FUNC_SET_MONTH: status_s1 = ST_BAD_MONTH;
				FUNC_SET_YEAR: status_s1 = ST_BAD_YEAR;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			cmd_s1 <= '0;
			date_q <= RESET_DATE;
		end else begin
			if (ready1) v_s1 <= cmd.valid;
			if (ready2) v_s2 <= v_s1;
			if (ready3) v_s3 <= v_s2;
			if (ready1 && cmd.valid) cmd_s1 <= cmd.data;
			if (fire1 && (status_s1 == ST_OK)) date_q <= cand;
		end
	end

	always_ff @(posedge clk) begin
		if (fire1) begin
			status_s2 <= status_s1;
			date_s2 <= (status_s1 == ST_OK) ? cand : date_q;
		end
		if (v_s2 && ready3) begin
			res_s3 <= '{status: status_s2, cur_day: date_s2.day, cur_month: date_s2.month,
				cur_year: date_s2.year, weekday: info.weekday, leap: info.leap,
				month_end: info.month_end};
		end
	end

	cdr_date_info u_info (
		.date(date_s2),
		.info(info)
	);

	assign res.valid = v_s3;
	assign res.data = res_s3;

`ifndef SYNTHESIS
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(date_q.month >= 4'd1) && (date_q.month <= 4'd12))
		else $error("stored month out of range");

	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire1 && (status_s1 != ST_OK) |=> date_q == $past(date_q))
		else $error("rejected command changed the stored date");

	a_commit: assert property (@(posedge clk) disable iff (!arst_n)
		fire1 && (status_s1 == ST_OK) |=> date_q == $past(cand))
		else $error("accepted command did not commit its date");

	a_month_end_day: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.month_end |-> res.data.cur_day >= 5'd28)
		else $error("last-day flag on an early day");
`endif

endmodule
